// ----- hdl/fan_pwm_speed_mode_controller_macros.svh -----
`ifndef FAN_PWM_SPEED_MODE_CONTROLLER_MACROS_SVH
`define FAN_PWM_SPEED_MODE_CONTROLLER_MACROS_SVH

// Same-cycle check, sampled on clk, held off during reset.
`define FPSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the next cycle.
`define FPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/fpsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fpsm_pkg;

	typedef enum logic [1:0] {
		MODE_STOP   = 2'd0,
		MODE_FAST   = 2'd1,
		MODE_MEDIUM = 2'd2,
		MODE_SLOW   = 2'd3
	} mode_t;

	typedef struct packed {
		logic tach_pulse;
		logic button_press;
	} in_t;

	typedef struct packed {
		logic       fan_on;
		logic [1:0] speed_mode;
		logic [7:0] revs_per_second;
		logic       alarm;
		logic [1:0] bar_level;
	} out_t;

	// one processed tick as seen by the state blocks
	typedef struct packed {
		logic adv;
		logic tach;
		logic press;
	} tick_t;

	typedef struct packed {
		logic  running;
		logic  fan_on;
		mode_t speed_mode;
	} pwm_stat_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_TICKS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSES_REV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_RPS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_LOW     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_MID     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_HIGH    = 3'd6;

	localparam logic [15:0] PWM_PERIOD_RST = 16'd3200;
	localparam logic [23:0] GATE_TICKS_RST = 24'd16000000;
	localparam logic [4:0]  PULSES_REV_RST = 5'd8;
	localparam logic [7:0]  ALARM_RPS_RST  = 8'd45;
	localparam logic [7:0]  BAR_LOW_RST    = 8'd18;
	localparam logic [7:0]  BAR_MID_RST    = 8'd27;
	localparam logic [7:0]  BAR_HIGH_RST   = 8'd40;

	// x/10 == (x * 838861) >> 23 for x < 2**22
	localparam int          RECIP10_SHIFT = 23;
	localparam logic [23:0] RECIP10       = 24'd838861;

	// tenths of the period for the given level (on = duty, off = 10 - duty)
	function automatic logic [3:0] phase_tenths(mode_t mode, logic level);
		logic [3:0] d;
		unique case (mode)
			MODE_FAST:   d = 4'd8;
			MODE_MEDIUM: d = 4'd5;
			MODE_SLOW:   d = 4'd3;
			MODE_STOP:   d = 4'd0;
		endcase
		return level ? d : 4'd10 - d;
	endfunction

	// tenths * RECIP10, so one multiply by the period gives period*tenths/10
	function automatic logic [23:0] phase_factor(logic [3:0] tenths);
		logic [23:0] f;
		unique case (tenths)
			4'd0:    f = 24'd0;
			4'd2:    f = 24'd1677722;
			4'd3:    f = 24'd2516583;
			4'd5:    f = 24'd4194305;
			4'd7:    f = 24'd5872027;
			4'd8:    f = 24'd6710888;
			4'd10:   f = 24'd8388610;
			default: f = 24'd0;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/fpsm_pwm.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpsm_pwm (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fpsm_pkg::tick_t   tick,
	input  wire logic [15:0]       pwm_period,
	output fpsm_pkg::pwm_stat_t    stat
);

	fpsm_pkg::mode_t mode_q, mode_d, sel_mode;
	logic            level_q, level_d, sel_level;
	logic [15:0]     pc_q, pc_d, pc_inc;
	logic [15:0]     pl_q, pl_d, phase_len;
	logic [39:0]     phase_prod;
	logic            load;

	assign phase_prod = 40'(pwm_period) * 40'(fpsm_pkg::phase_factor(
		fpsm_pkg::phase_tenths(sel_mode, sel_level)));
	assign phase_len  = phase_prod[fpsm_pkg::RECIP10_SHIFT +: 16];
	assign pc_inc     = pc_q + 16'd1;

	always_comb begin
		mode_d    = mode_q;
		level_d   = level_q;
		pc_d      = pc_q;
		sel_mode  = mode_q;
		sel_level = level_q;
		load      = 1'b0;
		if (tick.adv) begin
			if (tick.press) begin
				unique case (mode_q)
					fpsm_pkg::MODE_STOP:   mode_d = fpsm_pkg::MODE_FAST;
					fpsm_pkg::MODE_FAST:   mode_d = fpsm_pkg::MODE_MEDIUM;
					fpsm_pkg::MODE_MEDIUM: mode_d = fpsm_pkg::MODE_SLOW;
					fpsm_pkg::MODE_SLOW:   mode_d = fpsm_pkg::MODE_FAST;
				endcase
				pc_d     = '0;
				sel_mode = mode_d;
				load     = 1'b1;
			end else if (mode_q != fpsm_pkg::MODE_STOP) begin
				if (pc_inc >= pl_q) begin
					level_d   = ~level_q;
					pc_d      = '0;
					sel_level = level_d;
					load      = 1'b1;
				end else begin
					pc_d = pc_inc;
				end
			end
		end
		pl_d = load ? phase_len : pl_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= fpsm_pkg::MODE_STOP;
			level_q <= 1'b0;
			pc_q    <= '0;
			pl_q    <= fpsm_pkg::PWM_PERIOD_RST;
		end else begin
			mode_q  <= mode_d;
			level_q <= level_d;
			pc_q    <= pc_d;
			pl_q    <= pl_d;
		end
	end

	// running reflects the mode before this tick; the rest are post-tick values
	assign stat.running    = (mode_q != fpsm_pkg::MODE_STOP);
	assign stat.fan_on     = level_d;
	assign stat.speed_mode = mode_d;

endmodule

`default_nettype wire

// ----- hdl/fpsm_gate.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpsm_gate (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fpsm_pkg::tick_t tick,
	input  wire logic            running,
	input  wire logic [23:0]     gate_ticks,
	input  wire logic [4:0]      pulses_per_rev,
	output logic [7:0]           speed
);

	logic [3:0]  presc_q, presc_d;
	logic [4:0]  presc_inc, ppr;
	logic [7:0]  rev_q, rev_d, rev_t;
	logic [23:0] gate_q, gate_d, gate_inc, gate_eff;
	logic [7:0]  speed_q, speed_d;

	always_comb begin
		priority if (pulses_per_rev == 5'd0) ppr = 5'd1;
		else if (pulses_per_rev > 5'd16)     ppr = 5'd16;
		else                                 ppr = pulses_per_rev;
	end

	assign gate_eff  = (gate_ticks == '0) ? 24'd1 : gate_ticks;
	assign presc_inc = {1'b0, presc_q} + 5'd1;
	assign gate_inc  = gate_q + 24'd1;

	always_comb begin
		presc_d = presc_q;
		rev_t   = rev_q;
		gate_d  = gate_q;
		speed_d = speed_q;
		if (tick.adv && tick.tach) begin
			if (presc_inc >= ppr) begin
				presc_d = '0;
				rev_t   = (rev_q == 8'hFF) ? rev_q : rev_q + 8'd1;
			end else begin
				presc_d = presc_inc[3:0];
			end
		end
		rev_d = rev_t;
		if (tick.adv) begin
			if (tick.press) begin
				gate_d = '0;
			end else if (running) begin
				if (gate_inc >= gate_eff) begin
					gate_d  = '0;
					speed_d = rev_t;
					rev_d   = '0;
				end else begin
					gate_d = gate_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q <= '0;
			rev_q   <= '0;
			gate_q  <= '0;
			speed_q <= '0;
		end else begin
			presc_q <= presc_d;
			rev_q   <= rev_d;
			gate_q  <= gate_d;
			speed_q <= speed_d;
		end
	end

	assign speed = speed_d;

endmodule

`default_nettype wire

// ----- hdl/fan_pwm_speed_mode_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Fan PWM speed-mode controller.
// Input channel (in_valid/in_ready/in_data): one transaction per timer tick,
// carrying a tach pulse flag and a mode button flag.
// Output channel (out_valid/out_ready/out_data): one transaction per input,
// with fan drive level, speed mode, latched rev/s, alarm and bar level.
// Configuration: cfg_we/cfg_index/cfg_data write one register per clock;
// change them only while no transaction is in flight.
// Pipeline: input register, then result register; the result is valid once it
// reaches the result register and stays there until out_ready takes it.
// Throughput: one tick per cycle while out_ready is high; the whole state update
// sits between the two registers, with one 16x24 multiply for phase length.
// Reset: mode stopped, fan off, all counters clear, registers at defaults.
// When the receiver stalls, the result register holds and the input
// register takes one more tick; in_ready drops once both are full.
module fan_pwm_speed_mode_controller (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire fpsm_pkg::in_t                     in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output fpsm_pkg::out_t                         out_data,
	input  wire logic                              cfg_we,
	input  wire logic [fpsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fpsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [15:0] pwm_period_q;
	logic [23:0] gate_ticks_q;
	logic [4:0]  pulses_rev_q;
	logic [7:0]  alarm_rps_q, bar_low_q, bar_mid_q, bar_high_q;

	logic                valid_s1, valid_s2, s1_adv;
	fpsm_pkg::in_t       in_s1;
	fpsm_pkg::out_t      res_s2, res_d;
	fpsm_pkg::tick_t     tick;
	fpsm_pkg::pwm_stat_t pstat;
	logic [7:0]          speed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= fpsm_pkg::PWM_PERIOD_RST;
			gate_ticks_q <= fpsm_pkg::GATE_TICKS_RST;
			pulses_rev_q <= fpsm_pkg::PULSES_REV_RST;
			alarm_rps_q  <= fpsm_pkg::ALARM_RPS_RST;
			bar_low_q    <= fpsm_pkg::BAR_LOW_RST;
			bar_mid_q    <= fpsm_pkg::BAR_MID_RST;
			bar_high_q   <= fpsm_pkg::BAR_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpsm_pkg::REG_PWM_PERIOD: pwm_period_q <= cfg_data[15:0];
				fpsm_pkg::REG_GATE_TICKS: gate_ticks_q <= cfg_data[23:0];
				fpsm_pkg::REG_PULSES_REV: pulses_rev_q <= cfg_data[4:0];
				fpsm_pkg::REG_ALARM_RPS:  alarm_rps_q  <= cfg_data[7:0];
				fpsm_pkg::REG_BAR_LOW:    bar_low_q    <= cfg_data[7:0];
				fpsm_pkg::REG_BAR_MID:    bar_mid_q    <= cfg_data[7:0];
				fpsm_pkg::REG_BAR_HIGH:   bar_high_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign s1_adv   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (s1_adv)          valid_s1 <= 1'b0;
			if (s1_adv)               valid_s2 <= 1'b1;
			else if (out_ready)       valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) in_s1 <= in_data;
		if (s1_adv)               res_s2 <= res_d;
	end

	assign tick.adv   = s1_adv;
	assign tick.tach  = in_s1.tach_pulse;
	assign tick.press = in_s1.button_press;

	fpsm_pwm u_pwm (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.pwm_period (pwm_period_q),
		.stat       (pstat)
	);

	fpsm_gate u_gate (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (tick),
		.running        (pstat.running),
		.gate_ticks     (gate_ticks_q),
		.pulses_per_rev (pulses_rev_q),
		.speed          (speed)
	);

	always_comb begin
		res_d.fan_on          = pstat.fan_on;
		res_d.speed_mode      = pstat.speed_mode;
		res_d.revs_per_second = speed;
		res_d.alarm           = (pstat.speed_mode != fpsm_pkg::MODE_STOP) &&
			(speed >= alarm_rps_q);
		priority if (speed < bar_low_q) res_d.bar_level = 2'd1;
		else if (speed < bar_mid_q)     res_d.bar_level = 2'd2;
		else if (speed < bar_high_q)    res_d.bar_level = 2'd3;
		else                            res_d.bar_level = 2'd0;
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

`default_nettype wire

// ----- hdl/fpsm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "fan_pwm_speed_mode_controller_macros.svh"

module fpsm_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire fpsm_pkg::out_t out_data
);

	logic stalled;
	logic stop_shown;
	logic drive_shown;
	logic run_taken;

	assign stalled     = out_valid && !out_ready;
	assign stop_shown  = out_valid && (out_data.speed_mode == fpsm_pkg::MODE_STOP);
	assign drive_shown = out_data.fan_on || out_data.alarm;
	assign run_taken   = out_valid && out_ready && !stop_shown;

	`FPSM_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_data), "stalled result changed")
	`FPSM_ASSERT(a_stop_quiet, !(stop_shown && drive_shown), "fan or alarm active while stopped")
	`FPSM_ASSERT_NEXT(a_no_restop, run_taken, !stop_shown, "mode returned to stopped")

endmodule

bind fan_pwm_speed_mode_controller fpsm_checker u_fpsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int STALL_LIMIT = 2000;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_PERIODIC,
		RX_HEAVY
	} rx_style_t;

	// Tick-accurate model of the fan controller plus the queue of results it owes.
	class fan_tick_board;
		logic [15:0]     period;
		logic [23:0]     gate;
		logic [4:0]      ppr_cfg;
		logic [7:0]      alarm_th, bar_lo, bar_mid, bar_hi;
		fpsm_pkg::mode_t mode;
		logic            level;
		logic [15:0]     ph_cnt, ph_len;
		logic [23:0]     gate_cnt;
		logic [3:0]      prescale;
		logic [7:0]      revs, speed;
		fpsm_pkg::out_t  owed[$];
		int              errors;

		function new();
			period   = fpsm_pkg::PWM_PERIOD_RST;
			gate     = fpsm_pkg::GATE_TICKS_RST;
			ppr_cfg  = fpsm_pkg::PULSES_REV_RST;
			alarm_th = fpsm_pkg::ALARM_RPS_RST;
			bar_lo   = fpsm_pkg::BAR_LOW_RST;
			bar_mid  = fpsm_pkg::BAR_MID_RST;
			bar_hi   = fpsm_pkg::BAR_HIGH_RST;
			mode     = fpsm_pkg::MODE_STOP;
			level    = 1'b0;
			ph_cnt   = '0;
			ph_len   = fpsm_pkg::PWM_PERIOD_RST;
			gate_cnt = '0;
			prescale = '0;
			revs     = '0;
			speed    = '0;
			errors   = 0;
		endfunction

		function logic [15:0] phase_ticks(logic lvl);
			int unsigned d;
			int unsigned tenths;
			case (mode)
				fpsm_pkg::MODE_FAST:   d = 8;
				fpsm_pkg::MODE_MEDIUM: d = 5;
				fpsm_pkg::MODE_SLOW:   d = 3;
				default:               d = 0;
			endcase
			tenths = lvl ? d : 10 - d;
			return 16'((32'(period) * tenths) / 10);
		endfunction

		function void write_reg(logic [fpsm_pkg::CFG_IDX_W-1:0] idx,
				logic [fpsm_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				fpsm_pkg::REG_PWM_PERIOD: period   = data[15:0];
				fpsm_pkg::REG_GATE_TICKS: gate     = data[23:0];
				fpsm_pkg::REG_PULSES_REV: ppr_cfg  = data[4:0];
				fpsm_pkg::REG_ALARM_RPS:  alarm_th = data[7:0];
				fpsm_pkg::REG_BAR_LOW:    bar_lo   = data[7:0];
				fpsm_pkg::REG_BAR_MID:    bar_mid  = data[7:0];
				fpsm_pkg::REG_BAR_HIGH:   bar_hi   = data[7:0];
				default: ;
			endcase
		endfunction

		function void note_tick(fpsm_pkg::in_t t);
			int unsigned    ppr;
			logic [23:0]    gate_eff;
			fpsm_pkg::out_t o;
			ppr      = (ppr_cfg == 0) ? 1 : (ppr_cfg > 16) ? 16 : ppr_cfg;
			gate_eff = (gate == 0) ? 24'd1 : gate;

			// tach is counted before the mode logic
			if (t.tach_pulse) begin
				if (32'(prescale) + 1 >= ppr) begin
					prescale = '0;
					if (revs != 8'hFF)
						revs++;
				end else begin
					prescale++;
				end
			end

			if (t.button_press) begin
				mode     = (mode == fpsm_pkg::MODE_SLOW) ? fpsm_pkg::MODE_FAST :
					fpsm_pkg::mode_t'(mode + 2'd1);
				ph_cnt   = '0;
				gate_cnt = '0;
				ph_len   = phase_ticks(level);
			end else if (mode != fpsm_pkg::MODE_STOP) begin
				ph_cnt++;
				if (ph_cnt >= ph_len) begin
					level  = ~level;
					ph_cnt = '0;
					ph_len = phase_ticks(level);
				end
				gate_cnt++;
				if (gate_cnt >= gate_eff) begin
					gate_cnt = '0;
					speed    = revs;
					revs     = '0;
				end
			end

			o.fan_on          = level;
			o.speed_mode      = mode;
			o.revs_per_second = speed;
			o.alarm           = (mode != fpsm_pkg::MODE_STOP) && (speed >= alarm_th);
			if (speed < bar_lo)
				o.bar_level = 2'd1;
			else if (speed < bar_mid)
				o.bar_level = 2'd2;
			else if (speed < bar_hi)
				o.bar_level = 2'd3;
			else
				o.bar_level = 2'd0;
			owed.push_back(o);
		endfunction

		function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_tick(fpsm_pkg::out_t got);
			fpsm_pkg::out_t want;
			if (owed.size() == 0) begin
				$error("result transaction with no tick outstanding");
				errors++;
				return;
			end
			want = owed.pop_front();
			cmp_field("fan_on", 8'(want.fan_on), 8'(got.fan_on));
			cmp_field("speed_mode", 8'(want.speed_mode), 8'(got.speed_mode));
			cmp_field("revs_per_second", want.revs_per_second, got.revs_per_second);
			cmp_field("alarm", 8'(want.alarm), 8'(got.alarm));
			cmp_field("bar_level", 8'(want.bar_level), 8'(got.bar_level));
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	fpsm_pkg::in_t                   in_data = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	fpsm_pkg::out_t                  out_data;
	logic                            cfg_we = 1'b0;
	logic [fpsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fpsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	fan_tick_board board;
	rx_style_t     rx_style = RX_FREE;
	logic [15:0]   rx_cycle = '0;
	int            idle_cycles = 0;

	fan_pwm_speed_mode_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver back-pressure, style reshuffled whenever the low byte of rx_cycle is zero
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 16'd1;
		if (rx_cycle[7:0] == 8'd0)
			rx_style <= rx_style_t'($urandom_range(0, 3));
		case (rx_style)
			RX_FREE:     out_ready <= 1'b1;
			RX_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: out_ready <= ((rx_cycle % 5) < 3);
			default:     out_ready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_tick(out_data);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// hold valid until the transaction is taken, then predict it
	task automatic send_tick(logic tach, logic press);
		fpsm_pkg::in_t t;
		t.tach_pulse   = tach;
		t.button_press = press;
		in_valid <= 1'b1;
		in_data  <= t;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_tick(t);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.owed.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(logic [fpsm_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= fpsm_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		board.write_reg(idx, fpsm_pkg::CFG_DATA_W'(val));
	endtask

	task automatic program_regs(int unsigned period, int unsigned gate, int unsigned ppr,
			int unsigned alarm, int unsigned lo, int unsigned mid, int unsigned hi);
		put_reg(fpsm_pkg::REG_PWM_PERIOD, period);
		put_reg(fpsm_pkg::REG_GATE_TICKS, gate);
		put_reg(fpsm_pkg::REG_PULSES_REV, ppr);
		put_reg(fpsm_pkg::REG_ALARM_RPS, alarm);
		put_reg(fpsm_pkg::REG_BAR_LOW, lo);
		put_reg(fpsm_pkg::REG_BAR_MID, mid);
		put_reg(fpsm_pkg::REG_BAR_HIGH, hi);
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned pick(int unsigned top, int unsigned typ);
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return top;
			default: return $urandom_range(0, typ);
		endcase
	endfunction

	// press_div of 0 means no presses past the optional opening one
	task automatic run_phase(int n, int unsigned tach_pct, int unsigned press_div,
			bit first_press, int unsigned gap_max, bit pause_mid);
		int unsigned burst_left;
		int unsigned gap;
		logic        tach, press;
		burst_left = $urandom_range(1, 20);
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2)
				settle();
			if (burst_left == 0) begin
				gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 20);
			end
			tach  = ($urandom_range(0, 99) < tach_pct);
			press = (i == 0 && first_press) ||
				(press_div != 0 && $urandom_range(0, press_div) == 0);
			send_tick(tach, press);
			burst_left--;
		end
	endtask

	initial begin
		int unsigned tach_pct;
		int unsigned press_div;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stopped after reset, default registers: tach still accumulates
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		settle();

		// zero period, zero gate, zero prescale; alarm 0 must stay low while stopped
		program_regs(0, 0, 0, 0, 0, 255, 0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);

		for (int k = 0; k < 9; k++) begin
			settle();
			case (k)
				0: program_regs(10, 1, 1, 0, 0, 0, 0);
				1: program_regs(16'hFFFF, 24'hFFFFFF, 31, 255, 255, 255, 255);
				4: program_regs(pick(16'hFFFF, 60), 280, 1, 255,
					pick(255, 40), pick(255, 120), pick(255, 255));
				default: program_regs(pick(16'hFFFF, 60), 1 + pick(24'hFFFFFE, 59),
					pick(31, 16), pick(255, 40), pick(255, 40), pick(255, 40),
					pick(255, 40));
			endcase
			if (k == 4) begin
				// solid tach with ppr 1 over a long gate drives the rev count into saturation
				run_phase(300, 100, 0, 1'b1, $urandom_range(0, 4), 1'b0);
			end else begin
				tach_pct = $urandom_range(0, 100);
				case ($urandom_range(0, 2))
					0:       press_div = 8;
					1:       press_div = 80;
					default: press_div = 400;
				endcase
				run_phase(130, tach_pct, press_div, (k == 0),
					(k == 3) ? 0 : $urandom_range(0, 6), (k == 2));
			end
		end

		settle();
		repeat (6) @(posedge clk);
		if (board.errors == 0 && board.owed.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/fpsm_pkg.sv
hdl/fpsm_pwm.sv
hdl/fpsm_gate.sv
hdl/fan_pwm_speed_mode_controller.sv
hdl/fpsm_checker.sv
dv/tb.sv
